/* rtl/core/cacc_pkg.sv */
// ----------------------------------------------------------------------------
// cacc_pkg
// Shared types, constants and the saturation function of the complex
// accumulator.
// ----------------------------------------------------------------------------
package cacc_pkg;

	localparam int VALUE_W           = 32;
	localparam int EXP_W             = 16;
	localparam int CNT_W             = EXP_W - 1;
	localparam int PROD_W            = 2 * VALUE_W;
	localparam int SUM_W             = 2 * VALUE_W + 1;
	localparam int DEFAULT_FRAC_BITS = 16;
	localparam int STEP_W            = 3;
	localparam int IN_TDATA_W        = 2 * VALUE_W + EXP_W;
	localparam int OUT_TDATA_W       = 2 * VALUE_W;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(4);

	localparam logic signed [SUM_W-1:0] VMAX_WIDE =
		$signed({{(SUM_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] VMIN_WIDE =
		$signed({{(SUM_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}});

	typedef enum logic [2:0] {
		ACT_CLEAR   = 3'd0,
		ACT_ADD     = 3'd1,
		ACT_SUB     = 3'd2,
		ACT_MUL     = 3'd3,
		ACT_CONJ    = 3'd4,
		ACT_POW     = 3'd5,
		ACT_READ    = 3'd6,
		ACT_INVALID = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NEG_EXP = 2'd1,
		ST_BAD_ACT = 2'd2,
		ST_SAT     = 2'd3
	} status_t;

	typedef struct packed {
		logic              latch;
		logic              exec;
		logic              mul_en;
		logic [STEP_W-1:0] step;
		logic              sat_step;
		logic              wb;
		logic              load_out;
	} cmd_t;

	typedef struct packed {
		logic loop_req;
		logic wb_req;
		logic cnt_last;
		logic out_busy;
	} dp_stat_t;

	typedef struct packed {
		logic                      sat;
		logic signed [VALUE_W-1:0] val;
	} sat_t;

	function automatic sat_t sat_wide(input logic signed [SUM_W-1:0] v);
		sat_t r;
		if (v > VMAX_WIDE) begin
			r.sat = 1'b1;
			r.val = VMAX_WIDE[VALUE_W-1:0];
		end else if (v < VMIN_WIDE) begin
			r.sat = 1'b1;
			r.val = VMIN_WIDE[VALUE_W-1:0];
		end else begin
			r.sat = 1'b0;
			r.val = v[VALUE_W-1:0];
		end
		return r;
	endfunction

endpackage

/* rtl/core/cacc_ctrl.sv */
// ----------------------------------------------------------------------------
// cacc_ctrl
// Sequencer of the complex accumulator: takes a request, runs the execute
// step and, where the action needs them, the multiply, saturate and
// write-back steps, and hands the result to the output register.
// ----------------------------------------------------------------------------
module cacc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cacc_pkg::dp_stat_t stat,
	output cacc_pkg::cmd_t    cmd
);
	import cacc_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_MUL  = 6'b000100,
		S_SAT  = 6'b001000,
		S_WB   = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		cmd          = '0;
		cmd.step     = step_q;
		in_ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				step_d   = '0;
				if (stat.loop_req) begin
					state_d = S_MUL;
				end else if (stat.wb_req) begin
					state_d = S_WB;
				end else begin
					state_d = S_OUT;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				if (step_q == STEP_LAST) begin
					step_d  = '0;
					state_d = S_SAT;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			S_SAT: begin
				cmd.sat_step = 1'b1;
				if (stat.cnt_last) begin
					state_d = S_WB;
				end else begin
					state_d = S_MUL;
				end
			end
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

/* rtl/core/cacc_dp.sv */
// ----------------------------------------------------------------------------
// cacc_dp
// Datapath of the complex accumulator: accumulator and working registers,
// one shared 32x32 multiplier with product register, wide sums, saturation
// and the output register.
// ----------------------------------------------------------------------------
module cacc_dp #(
	parameter int FRAC_BITS = cacc_pkg::DEFAULT_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cacc_pkg::cmd_t                       cmd,
	output cacc_pkg::dp_stat_t                   stat,
	input  logic [2:0]                           in_action,
	input  logic signed [cacc_pkg::VALUE_W-1:0]  in_re,
	input  logic signed [cacc_pkg::VALUE_W-1:0]  in_im,
	input  logic signed [cacc_pkg::EXP_W-1:0]    in_exp,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [cacc_pkg::VALUE_W-1:0]         out_re,
	output logic [cacc_pkg::VALUE_W-1:0]         out_im,
	output logic [1:0]                           out_status
);
	import cacc_pkg::*;

	localparam logic signed [SUM_W-1:0] ONE_WIDE = SUM_W'(1) <<< FRAC_BITS;

	action_t                   action_q;
	logic signed [VALUE_W-1:0] op_re_q, op_im_q;
	logic signed [EXP_W-1:0]   exp_q;
	logic signed [VALUE_W-1:0] acc_re_q, acc_im_q;
	logic signed [VALUE_W-1:0] w_re_q, w_im_q;
	logic signed [VALUE_W-1:0] b_re_q, b_im_q;
	logic signed [PROD_W-1:0]  p_q;
	logic signed [SUM_W-1:0]   re_sum_q, im_sum_q;
	logic [CNT_W-1:0]          cnt_q;
	status_t                   code_q;
	logic                      sat_q;
	logic                      out_vld_q;
	logic [VALUE_W-1:0]        out_re_q, out_im_q;
	status_t                   out_st_q;

	logic signed [VALUE_W-1:0] mul_a, mul_b;
	sat_t                      one_r, add_re, add_im, sub_re, sub_im, conj_im;
	sat_t                      prod_re, prod_im;
	logic                      exp_neg, exp_zero;

	assign exp_neg  = exp_q[EXP_W-1];
	assign exp_zero = (exp_q == '0);

	assign one_r   = sat_wide(ONE_WIDE);
	assign add_re  = sat_wide(SUM_W'(acc_re_q) + SUM_W'(op_re_q));
	assign add_im  = sat_wide(SUM_W'(acc_im_q) + SUM_W'(op_im_q));
	assign sub_re  = sat_wide(SUM_W'(acc_re_q) - SUM_W'(op_re_q));
	assign sub_im  = sat_wide(SUM_W'(acc_im_q) - SUM_W'(op_im_q));
	assign conj_im = sat_wide(-SUM_W'(acc_im_q));
	assign prod_re = sat_wide(re_sum_q >>> FRAC_BITS);
	assign prod_im = sat_wide(im_sum_q >>> FRAC_BITS);

	always_comb begin
		case (cmd.step[1:0])
			2'd0: begin
				mul_a = w_re_q;
				mul_b = b_re_q;
			end
			2'd1: begin
				mul_a = w_im_q;
				mul_b = b_im_q;
			end
			2'd2: begin
				mul_a = w_re_q;
				mul_b = b_im_q;
			end
			default: begin
				mul_a = w_im_q;
				mul_b = b_re_q;
			end
		endcase
	end

	assign stat.loop_req = (action_q == ACT_MUL) ||
		((action_q == ACT_POW) && !exp_neg && !exp_zero);
	assign stat.wb_req   = (action_q == ACT_POW) && !exp_neg && exp_zero;
	assign stat.cnt_last = (cnt_q == CNT_W'(1));
	assign stat.out_busy = out_vld_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q <= action_t'(in_action);
			op_re_q  <= in_re;
			op_im_q  <= in_im;
			exp_q    <= in_exp;
		end
		if (cmd.mul_en) begin
			if (cmd.step != STEP_LAST) begin
				p_q <= mul_a * mul_b;
			end
			case (cmd.step)
				STEP_W'(1): re_sum_q <= SUM_W'(p_q);
				STEP_W'(2): re_sum_q <= re_sum_q - SUM_W'(p_q);
				STEP_W'(3): im_sum_q <= SUM_W'(p_q);
				STEP_W'(4): im_sum_q <= im_sum_q + SUM_W'(p_q);
				default: begin
				end
			endcase
		end
		if (cmd.sat_step) begin
			w_re_q <= prod_re.val;
			w_im_q <= prod_im.val;
			cnt_q  <= cnt_q - CNT_W'(1);
		end
		if (cmd.exec) begin
			case (action_q)
				ACT_MUL: begin
					w_re_q <= acc_re_q;
					w_im_q <= acc_im_q;
					b_re_q <= op_re_q;
					b_im_q <= op_im_q;
					cnt_q  <= CNT_W'(1);
				end
				ACT_POW: begin
					w_re_q <= one_r.val;
					w_im_q <= '0;
					b_re_q <= acc_re_q;
					b_im_q <= acc_im_q;
					cnt_q  <= exp_q[CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
		if (cmd.load_out) begin
			out_re_q <= acc_re_q;
			out_im_q <= acc_im_q;
			out_st_q <= (code_q == ST_OK && sat_q) ? ST_SAT : code_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_re_q  <= '0;
			acc_im_q  <= '0;
			code_q    <= ST_OK;
			sat_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				code_q <= ST_OK;
				sat_q  <= 1'b0;
				case (action_q)
					ACT_CLEAR: begin
						acc_re_q <= '0;
						acc_im_q <= '0;
					end
					ACT_ADD: begin
						acc_re_q <= add_re.val;
						acc_im_q <= add_im.val;
						sat_q    <= add_re.sat || add_im.sat;
					end
					ACT_SUB: begin
						acc_re_q <= sub_re.val;
						acc_im_q <= sub_im.val;
						sat_q    <= sub_re.sat || sub_im.sat;
					end
					ACT_CONJ: begin
						acc_im_q <= conj_im.val;
						sat_q    <= conj_im.sat;
					end
					ACT_POW: begin
						if (exp_neg) begin
							code_q <= ST_NEG_EXP;
						end else begin
							sat_q <= one_r.sat;
						end
					end
					ACT_INVALID: begin
						code_q <= ST_BAD_ACT;
					end
					default: begin
					end
				endcase
			end
			if (cmd.sat_step && (prod_re.sat || prod_im.sat)) begin
				sat_q <= 1'b1;
			end
			if (cmd.wb) begin
				acc_re_q <= w_re_q;
				acc_im_q <= w_im_q;
			end
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_vld_q;
	assign out_re     = out_re_q;
	assign out_im     = out_im_q;
	assign out_status = out_st_q;

endmodule

/* rtl/core/complex_accumulator_alu.sv */
// Multiply and power run the shared multiplier, which forms four products
// per pass; a power of n takes n passes, the other actions none.
// Throughput: one request at a time; the next is taken when the result is
// in the output register, which frees when the sink takes it.
// Reset: asynchronous, active low; clears the accumulator and the control.
// ----------------------------------------------------------------------------
// complex_accumulator_alu
// Complex accumulator in signed fixed point with add, subtract, multiply,
// conjugate, power, clear and read actions and saturating results.
// ----------------------------------------------------------------------------
module complex_accumulator_alu #(
	parameter int FRAC_BITS = cacc_pkg::DEFAULT_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// operand_re [31:0], operand_im [63:32], exponent [79:64]
	input  logic [cacc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// action [2:0]
	input  logic [2:0]                           s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// value_re [31:0], value_im [63:32]
	output logic [cacc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// status [1:0]
	output logic [1:0]                           m_axis_tuser
);
	import cacc_pkg::*;

	cmd_t               cmd;
	dp_stat_t           stat;
	logic [VALUE_W-1:0] out_re, out_im;

	cacc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cacc_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_action  (s_axis_tuser),
		.in_re      ($signed(s_axis_tdata[VALUE_W-1:0])),
		.in_im      ($signed(s_axis_tdata[2*VALUE_W-1:VALUE_W])),
		.in_exp     ($signed(s_axis_tdata[IN_TDATA_W-1:2*VALUE_W])),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_re     (out_re),
		.out_im     (out_im),
		.out_status (m_axis_tuser)
	);

	assign m_axis_tdata = {out_im, out_re};

endmodule

/* rtl/core/cacc_chk.sv */
// ----------------------------------------------------------------------------
// cacc_chk
// Port-level checks of the complex accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module cacc_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [cacc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic [1:0]                        m_axis_tuser
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value and status.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// Only one request is in work at a time.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second request taken while busy");

	// The block becomes ready again only when it offers the result.
	a_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_axis_tready) |-> m_axis_tvalid)
		else $error("ready again without a result");

endmodule

bind complex_accumulator_alu cacc_chk u_cacc_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
